[hdl/acck_pkg.sv]
// ----------------------------------------------------------------------------
// acck_pkg
// types, key codes and limits shared by the alarm clock keypad controller
// ----------------------------------------------------------------------------
`default_nettype none

package acck_pkg;

  localparam int ENTRY_LEN = 4;

  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_TIME = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  localparam logic [7:0] KEY_NONE   = 8'h00;
  localparam logic [7:0] KEY_ENTER  = 8'h41;
  localparam logic [7:0] KEY_CLEAR  = 8'h43;
  localparam logic [7:0] KEY_CANCEL = 8'h2A;
  localparam logic [7:0] KEY_SAVE   = 8'h23;
  localparam logic [7:0] KEY_DIGIT0 = 8'h30;
  localparam logic [7:0] KEY_DIGIT9 = 8'h39;

  localparam logic [7:0] MAX_HOUR   = 8'd23;
  localparam logic [7:0] MAX_MINUTE = 8'd59;

  localparam logic [4:0] RESET_HOUR   = 5'd7;
  localparam logic [5:0] RESET_MINUTE = 6'd30;

  localparam logic [2:0] COUNT_FULL = 3'(ENTRY_LEN);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key_code;
    logic       time_valid;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } acck_item_t;

  typedef struct packed {
    logic       mode;
    logic       ring;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] count;
  } acck_ctrl_t;

  typedef logic [ENTRY_LEN-1:0][3:0] acck_entry_t;

  typedef struct packed {
    logic        mode;
    logic        ringing;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [2:0]  digit_count;
    logic [15:0] entered_digits;
  } acck_result_t;

endpackage

`default_nettype wire

[hdl/acck_step.sv]
// ----------------------------------------------------------------------------
// acck_step
// next control state, entry store write and result word for one event
// ----------------------------------------------------------------------------
`default_nettype none

module acck_step (
  input  acck_pkg::acck_item_t   item,
  input  acck_pkg::acck_ctrl_t   ctrl,
  input  acck_pkg::acck_entry_t  entry,
  output acck_pkg::acck_ctrl_t   ctrl_nxt,
  output acck_pkg::acck_entry_t  entry_nxt,
  output acck_pkg::acck_result_t result
);
  import acck_pkg::*;

  logic       is_digit;
  logic [7:0] save_hour;
  logic [7:0] save_minute;
  logic       save_ok;

  assign is_digit = (item.key_code >= KEY_DIGIT0) && (item.key_code <= KEY_DIGIT9);
  assign save_hour   = 8'(entry[0]) * 8'd10 + 8'(entry[1]);
  assign save_minute = 8'(entry[2]) * 8'd10 + 8'(entry[3]);
  assign save_ok = (ctrl.count == COUNT_FULL) && (save_hour <= MAX_HOUR) &&
                   (save_minute <= MAX_MINUTE);

  always_comb begin
    ctrl_nxt  = ctrl;
    entry_nxt = entry;
    unique case (item.op)
      OP_KEY: begin
        if (item.key_code != KEY_NONE) begin
          if (!ctrl.mode) begin
            if (item.key_code == KEY_ENTER) begin
              ctrl_nxt.mode  = 1'b1;
              ctrl_nxt.count = '0;
            end else begin
              ctrl_nxt.ring = 1'b0;
            end
          end else if (is_digit && (ctrl.count < COUNT_FULL)) begin
            entry_nxt[ctrl.count[1:0]] = item.key_code[3:0];
            ctrl_nxt.count = ctrl.count + 3'd1;
          end else if (item.key_code == KEY_CLEAR) begin
            ctrl_nxt.count = '0;
          end else if (item.key_code == KEY_CANCEL) begin
            ctrl_nxt.mode = 1'b0;
          end else if (item.key_code == KEY_SAVE) begin
            if (save_ok) begin
              ctrl_nxt.hour   = save_hour[4:0];
              ctrl_nxt.minute = save_minute[5:0];
            end
            ctrl_nxt.mode = 1'b0;
          end
        end
      end
      OP_TIME: begin
        if (!ctrl.mode && item.time_valid && (item.now_hour == ctrl.hour) &&
            (item.now_minute == ctrl.minute) && (item.now_second == 6'd0)) begin
          ctrl_nxt.ring = 1'b1;
        end
      end
      OP_STOP: begin
        ctrl_nxt.ring = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.mode           = ctrl_nxt.mode;
    result.ringing        = ctrl_nxt.ring;
    result.alarm_hour     = ctrl_nxt.hour;
    result.alarm_minute   = ctrl_nxt.minute;
    result.digit_count    = ctrl_nxt.mode ? ctrl_nxt.count : 3'd0;
    result.entered_digits = '0;
    for (int i = 0; i < ENTRY_LEN; i++) begin
      if (ctrl_nxt.mode && (3'(i) < ctrl_nxt.count)) begin
        result.entered_digits[15-4*i -: 4] = entry_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/alarm_clock_keypad_controller_core.sv]
// ----------------------------------------------------------------------------
// alarm_clock_keypad_controller_core
// alarm clock controller with normal and alarm setting modes, driven by keys,
// time samples and a stop button
// event word registered, then result word with the single state update
// throughput: one event word per cycle unless stalled by out_ready
// reset: synchronous, clears mode, ringing and digit count, alarm 07:30
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_keypad_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_key_code,
  input  wire logic        in_time_valid,
  input  wire logic [4:0]  in_now_hour,
  input  wire logic [5:0]  in_now_minute,
  input  wire logic [5:0]  in_now_second,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic        out_mode,
  output      logic        out_ringing,
  output      logic [4:0]  out_alarm_hour,
  output      logic [5:0]  out_alarm_minute,
  output      logic [2:0]  out_digit_count,
  output      logic [15:0] out_entered_digits
);
  import acck_pkg::*;

  logic         in_valid_r;
  acck_item_t   item_r;
  acck_ctrl_t   ctrl_r;
  acck_ctrl_t   ctrl_nxt;
  acck_entry_t  entry_r;
  acck_entry_t  entry_nxt;
  acck_result_t result_nxt;
  acck_result_t result_r;
  logic         out_valid_r;
  logic         advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.op         <= in_op;
      item_r.key_code   <= in_key_code;
      item_r.time_valid <= in_time_valid;
      item_r.now_hour   <= in_now_hour;
      item_r.now_minute <= in_now_minute;
      item_r.now_second <= in_now_second;
    end
  end

  acck_step u_step (
    .item      (item_r),
    .ctrl      (ctrl_r),
    .entry     (entry_r),
    .ctrl_nxt  (ctrl_nxt),
    .entry_nxt (entry_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.mode   <= 1'b0;
      ctrl_r.ring   <= 1'b0;
      ctrl_r.hour   <= RESET_HOUR;
      ctrl_r.minute <= RESET_MINUTE;
      ctrl_r.count  <= '0;
    end else if (advance) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_r  <= entry_nxt;
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = result_r.mode;
  assign out_ringing        = result_r.ringing;
  assign out_alarm_hour     = result_r.alarm_hour;
  assign out_alarm_minute   = result_r.alarm_minute;
  assign out_digit_count    = result_r.digit_count;
  assign out_entered_digits = result_r.entered_digits;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.count <= COUNT_FULL)
    else $error("digit count above entry length");

  a_alarm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.hour <= 5'(MAX_HOUR)) && (ctrl_r.minute <= 6'(MAX_MINUTE)))
    else $error("stored alarm out of range");

  a_normal_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_mode) |-> (out_digit_count == 3'd0) &&
      (out_entered_digits == 16'd0))
    else $error("entry fields nonzero in normal mode");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid && (out_ringing == ctrl_r.ring) &&
      (out_mode == ctrl_r.mode))
    else $error("result word does not match updated state");

endmodule

`default_nettype wire
